// File: sv/dhwv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwv_pkg
// shared types and constants of the direction history window vote block
// ----------------------------------------------------------------------------
package dhwv_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int NUM_HEADINGS_DEF  = 12;

  localparam int HEAD_W  = 4;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int TALLY_W = 32;
  localparam int PROD_W  = TIME_W + CNT_W;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CNT_W-1:0] SAMPLES_MAX = {CNT_W{1'b1}};

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [TIME_W-1:0] stamp;
    logic [CNT_W-1:0]  cnt;
  } node_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] dvs;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_WALK,
    ST_DIV,
    ST_ADD,
    ST_PICK,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_STEP
  } div_phase_t;

endpackage

// File: sv/dhwv_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwv_mem
// node ring store, one write and one registered read port
// ----------------------------------------------------------------------------
module dhwv_mem import dhwv_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int NUM_HEADINGS  = NUM_HEADINGS_DEF,
  parameter int SW            = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic          wr_new,
  input  logic [SW-1:0] wr_addr,
  input  node_t         wr_data,
  input  logic [SW-1:0] newest_slot,
  input  logic [SW-1:0] rd_addr,
  output node_t         rd_q
);

  node_t  mem_r [HISTORY_DEPTH];
  node_t  q_raw_r;
  logic   q_vld_r;
  logic   s0_wr_r;
  logic   wrapped_r;
  logic   rd_vld;

  // slots above the newest one hold reset values until the ring wraps
  assign rd_vld = (rd_addr == '0) ? s0_wr_r : (wrapped_r || (rd_addr <= newest_slot));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    q_raw_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_wr_r   <= 1'b0;
      wrapped_r <= 1'b0;
      q_vld_r   <= 1'b0;
    end else begin
      q_vld_r <= rd_vld;
      if (wr_en && wr_addr == '0) begin
        s0_wr_r <= 1'b1;
        if (wr_new) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  assign rd_q = q_vld_r ? q_raw_r : '{head: HEAD_W'(NUM_HEADINGS), stamp: '0, cnt: '0};

endmodule

// File: sv/dhwv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwv_div
// multiply then restoring divide, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dhwv_div import dhwv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [CNT_W-1:0] quot
);

  div_phase_t         phase_r, phase_nxt;
  logic [TIME_W-1:0]  num_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TIME_W-1:0]  dvs_r;
  logic [PROD_W-1:0]  work_r, work_nxt;
  logic [3:0]         step_r, step_nxt;
  logic               done_r, done_nxt;
  logic [TIME_W:0]    trial;
  logic [TIME_W:0]    diff;
  logic               fits;

  // quotient is known to fit in CNT_W bits, so the high word starts below the divisor
  assign trial = {work_r[PROD_W-1:CNT_W], work_r[CNT_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      DV_IDLE: if (req.start) phase_nxt = DV_MUL;
      DV_MUL:  phase_nxt = DV_STEP;
      DV_STEP: if (step_r == 4'(CNT_W - 1)) phase_nxt = DV_IDLE;
      default: phase_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    work_nxt = work_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    case (phase_r)
      DV_MUL: begin
        work_nxt = {{CNT_W{1'b0}}, num_r} * {{TIME_W{1'b0}}, cnt_r};
        step_nxt = '0;
      end
      DV_STEP: begin
        work_nxt = {(fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0]),
                    work_r[CNT_W-2:0], fits};
        step_nxt = step_r + 4'd1;
        done_nxt = (step_r == 4'(CNT_W - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == DV_IDLE && req.start) begin
      num_r <= req.num;
      cnt_r <= req.cnt;
      dvs_r <= req.dvs;
    end
    work_r <= work_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign quot = work_r[CNT_W-1:0];

endmodule

// File: sv/direction_history_window_vote.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_history_window_vote
// run-length direction history with a time-weighted window vote
// ----------------------------------------------------------------------------
// input channel (in_): tuser selects the transaction kind, 0 adds a direction
// sample, 1 queries the best direction over a window; tdata carries stamp,
// heading and window_ms. output channel (out_): one transaction per query
// with best_heading, none per sample.
// a sample is accepted in the idle state and in_tready is high again on the next cycle.
// a query walks the node ring one node per cycle through the registered
// read port of the node store: it finds the node holding the end time and
// adds up the older ones, then makes one or two multiply/divide passes
// (the shared divider, then a step to add the share), scans the headings
// to pick the winner and loads the output register; when the window starts
// at or after the newest node's end, the query goes straight to the output
// register.
// in_tready is low while a query is in progress.
// reset empties the history: every node reads as unknown with zero time
// and count; no clearing pass is needed.
// a stalled result is held in the output register; a further query waits at
// its end until that register is free, and in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module direction_history_window_vote import dhwv_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int NUM_HEADINGS  = NUM_HEADINGS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // stamp[31:0], heading[35:32], window_ms[67:36]
  input  logic                   in_tuser,   // func[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // best_heading[3:0]
);

  localparam int SW      = $clog2(HISTORY_DEPTH);
  localparam int TALLY_N = NUM_HEADINGS + 1;
  localparam logic [SW-1:0]     LAST_SLOT = SW'(HISTORY_DEPTH - 1);
  localparam logic [HEAD_W-1:0] UNK       = HEAD_W'(NUM_HEADINGS);
  localparam logic [HEAD_W-1:0] LAST_HEAD = HEAD_W'(NUM_HEADINGS - 1);

  function automatic logic [SW-1:0] slot_before(input logic [SW-1:0] s);
    return (s == '0) ? LAST_SLOT : s - SW'(1);
  endfunction

  function automatic logic [SW-1:0] slot_after(input logic [SW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  state_t              state_r, state_nxt;
  logic [SW-1:0]       newest_r, newest_nxt;
  node_t               nw_r, nw_nxt;
  logic [SW-1:0]       cur_slot_r, cur_slot_nxt;
  node_t               cur_r, cur_nxt;
  logic [TIME_W-1:0]   span_r, span_nxt;
  logic [TIME_W-1:0]   end_r, end_nxt;
  logic [HEAD_W-1:0]   div_head_r, div_head_nxt;
  logic                cont_r, cont_nxt;
  logic [TALLY_W-1:0]  tally_r [TALLY_N];
  logic [HEAD_W-1:0]   pick_r, pick_nxt;
  logic [TALLY_W-1:0]  top_r, top_nxt;
  logic [HEAD_W-1:0]   best_r, best_nxt;
  logic [HEAD_W-1:0]   res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HEAD_W-1:0]   out_head_r, out_head_nxt;

  logic                acc;
  logic [TIME_W-1:0]   in_stamp;
  logic [HEAD_W-1:0]   in_heading;
  logic [TIME_W-1:0]   in_window;
  logic [HEAD_W-1:0]   samp_head;
  logic [TIME_W-1:0]   gap;
  logic                q_late, gap_cover;
  logic [SW-1:0]       p_slot;
  logic                at_newest;
  node_t               rd_q;
  logic                srch_older;
  logic [TIME_W-1:0]   part_span, dur;
  logic                inside_cover, dur_cover;
  logic                pick_last, out_free;
  logic                tally_clr, tally_we;
  logic [HEAD_W-1:0]   tally_idx;
  logic [TALLY_W-1:0]  tally_add;
  logic [TALLY_W-1:0]  tally_rd;
  logic                pick_better;

  logic                mem_we, mem_new;
  logic [SW-1:0]       mem_waddr;
  node_t               mem_wdata;
  div_req_t            div_req;
  logic                div_done;
  logic [CNT_W-1:0]    div_quot;

  assign acc        = in_tvalid && in_tready;
  assign in_stamp   = in_tdata[31:0];
  assign in_heading = in_tdata[35:32];
  assign in_window  = in_tdata[67:36];
  assign samp_head  = (in_heading > UNK) ? UNK : in_heading;

  assign gap       = in_stamp - nw_r.stamp;
  assign q_late    = in_stamp >= nw_r.stamp;
  assign gap_cover = gap >= in_window;

  assign p_slot       = slot_before(cur_slot_r);
  assign at_newest    = p_slot == newest_r;
  assign srch_older   = rd_q.stamp > end_r;
  assign part_span    = end_r - rd_q.stamp;
  assign inside_cover = part_span >= span_r;
  assign dur          = cur_r.stamp - rd_q.stamp;
  assign dur_cover    = dur >= span_r;
  assign pick_last    = pick_r == LAST_HEAD;
  assign out_free     = !out_valid_r || out_tready;

  assign tally_rd    = tally_r[tally_idx];
  assign pick_better = tally_rd > top_r;

  dhwv_mem #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .NUM_HEADINGS  (NUM_HEADINGS),
    .SW            (SW)
  ) u_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (mem_we),
    .wr_new      (mem_new),
    .wr_addr     (mem_waddr),
    .wr_data     (mem_wdata),
    .newest_slot (newest_r),
    .rd_addr     (slot_before(cur_slot_nxt)),
    .rd_q        (rd_q)
  );

  dhwv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_tuser == FUNC_QUERY) begin
          if (q_late && gap_cover) state_nxt = ST_OUT;
          else if (q_late)         state_nxt = ST_WALK;
          else                     state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (at_newest)         state_nxt = ST_OUT;
        else if (srch_older)   state_nxt = ST_SRCH;
        else if (inside_cover) state_nxt = ST_OUT;
        else                   state_nxt = ST_DIV;
      end
      ST_WALK: begin
        if (at_newest)      state_nxt = ST_PICK;
        else if (dur_cover) state_nxt = ST_DIV;
      end
      ST_DIV:  if (div_done) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = cont_r ? ST_WALK : ST_PICK;
      ST_PICK: if (pick_last) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake, store write, divider request and tally port
  always_comb begin
    in_tready = state_r == ST_IDLE;
    mem_we    = 1'b0;
    mem_new   = 1'b0;
    mem_waddr = newest_r;
    mem_wdata = nw_r;
    div_req   = '0;
    tally_clr = 1'b0;
    tally_we  = 1'b0;
    tally_idx = cur_r.head;
    tally_add = TALLY_W'(cur_r.cnt);
    case (state_r)
      ST_IDLE: begin
        if (acc && in_tuser == FUNC_SAMPLE) begin
          mem_we = 1'b1;
          if (nw_r.head == samp_head) begin
            mem_wdata = '{head: samp_head, stamp: in_stamp,
                          cnt: (nw_r.cnt == SAMPLES_MAX) ? nw_r.cnt : nw_r.cnt + CNT_W'(1)};
          end else begin
            mem_new   = 1'b1;
            mem_waddr = slot_after(newest_r);
            mem_wdata = '{head: samp_head, stamp: in_stamp, cnt: CNT_W'(1)};
          end
        end
        tally_clr = acc && in_tuser == FUNC_QUERY;
      end
      ST_SRCH: begin
        if (!at_newest && !srch_older && !inside_cover) begin
          div_req = '{start: 1'b1, num: part_span, cnt: cur_r.cnt,
                      dvs: (dur == '0) ? TIME_W'(1) : dur};
        end
      end
      ST_WALK: begin
        if (!at_newest) begin
          if (dur_cover) begin
            div_req = '{start: 1'b1, num: span_r, cnt: cur_r.cnt,
                        dvs: (dur == '0) ? TIME_W'(1) : dur};
          end else begin
            tally_we = 1'b1;
          end
        end
      end
      ST_ADD: begin
        tally_we  = 1'b1;
        tally_idx = div_head_r;
        tally_add = TALLY_W'(div_quot);
      end
      ST_PICK: tally_idx = pick_r;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    newest_nxt    = newest_r;
    nw_nxt        = nw_r;
    cur_slot_nxt  = cur_slot_r;
    cur_nxt       = cur_r;
    span_nxt      = span_r;
    end_nxt       = end_r;
    div_head_nxt  = div_head_r;
    cont_nxt      = cont_r;
    pick_nxt      = pick_r;
    top_nxt       = top_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_head_nxt  = out_head_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_tuser == FUNC_SAMPLE) begin
          nw_nxt = mem_wdata;
          if (mem_new) newest_nxt = mem_waddr;
        end else if (acc) begin
          end_nxt      = in_stamp;
          cur_nxt      = nw_r;
          cur_slot_nxt = newest_r;
          res_nxt      = nw_r.head;
          span_nxt     = q_late ? in_window - gap : in_window;
        end
      end
      ST_SRCH: begin
        res_nxt = cur_r.head;
        if (!at_newest && srch_older) begin
          cur_nxt      = rd_q;
          cur_slot_nxt = p_slot;
        end else if (!at_newest && !inside_cover) begin
          div_head_nxt = cur_r.head;
          cont_nxt     = 1'b1;
          span_nxt     = span_r - part_span;
          cur_nxt      = rd_q;
          cur_slot_nxt = p_slot;
        end
      end
      ST_WALK: begin
        if (!at_newest) begin
          if (dur_cover) begin
            div_head_nxt = cur_r.head;
            cont_nxt     = 1'b0;
          end else begin
            span_nxt     = span_r - dur;
            cur_nxt      = rd_q;
            cur_slot_nxt = p_slot;
          end
        end
      end
      ST_PICK: begin
        if (pick_better) begin
          top_nxt  = tally_rd;
          best_nxt = pick_r;
        end
        pick_nxt = pick_r + HEAD_W'(1);
        res_nxt  = pick_better ? pick_r : best_r;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_head_nxt  = res_r;
        end
      end
      default: ;
    endcase
    // vote scan starts fresh on entry
    if (state_r != ST_PICK && state_nxt == ST_PICK) begin
      pick_nxt = '0;
      top_nxt  = '0;
      best_nxt = UNK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      newest_r    <= '0;
      nw_r        <= '{head: UNK, stamp: '0, cnt: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      nw_r        <= nw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_slot_r <= cur_slot_nxt;
    cur_r      <= cur_nxt;
    span_r     <= span_nxt;
    end_r      <= end_nxt;
    div_head_r <= div_head_nxt;
    cont_r     <= cont_nxt;
    pick_r     <= pick_nxt;
    top_r      <= top_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_head_r <= out_head_nxt;
    for (int i = 0; i < TALLY_N; i++) begin
      if (tally_clr) begin
        tally_r[i] <= '0;
      end
    end
    if (tally_we) begin
      tally_r[tally_idx] <= tally_rd + tally_add;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - HEAD_W){1'b0}}, out_head_r};

endmodule

// File: sv/dhwv_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwv_chk
// port-level checks of the direction history window vote block
// ----------------------------------------------------------------------------
module dhwv_chk import dhwv_pkg::*; #(
  parameter int NUM_HEADINGS = NUM_HEADINGS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= OUT_TDATA_W'(NUM_HEADINGS))
    else $error("result heading out of range");

  // a sample transaction leaves the input ready for the next one
  a_sample_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_SAMPLE |=> in_tready)
    else $error("not ready after sample");

  // a query keeps the input side closed while it runs
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_QUERY |=> !in_tready)
    else $error("ready during query");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind direction_history_window_vote dhwv_chk #(.NUM_HEADINGS(NUM_HEADINGS)) u_dhwv_chk (.*);

// File: tb/dhwv_vote_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwv_vote_checker
// watches both channels of the direction history window vote block, keeps
// its own copy of the node ring, predicts each query's answer and compares
// ----------------------------------------------------------------------------
module dhwv_vote_checker import dhwv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending_answers
);

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int NHEAD = NUM_HEADINGS_DEF;
  localparam logic [HEAD_W-1:0] UNKNOWN = HEAD_W'(NHEAD);

  logic [HEAD_W-1:0] ring_head  [DEPTH];
  logic [TIME_W-1:0] ring_stamp [DEPTH];
  logic [CNT_W-1:0]  ring_cnt   [DEPTH];
  int unsigned       newest;
  logic [HEAD_W-1:0] answer_q[$];

  function automatic int unsigned prev_slot(int unsigned s);
    return (s == 0) ? DEPTH - 1 : s - 1;
  endfunction

  function automatic logic [TIME_W-1:0] share(logic [TIME_W-1:0] span,
                                             logic [CNT_W-1:0] cnt,
                                             logic [TIME_W-1:0] dur);
    logic [63:0] prod;
    logic [63:0] dv;
    prod = 64'(span) * 64'(cnt);
    dv = (dur == 0) ? 64'd1 : 64'(dur);
    return TIME_W'(prod / dv);
  endfunction

  task automatic tally_back(int unsigned from, logic [TIME_W-1:0] span,
                            ref logic [TIME_W-1:0] tally[NHEAD+1]);
    int unsigned at;
    int unsigned back;
    logic [TIME_W-1:0] dur;
    at = from;
    while (span > 0) begin
      back = prev_slot(at);
      if (back == newest) break;
      dur = ring_stamp[at] - ring_stamp[back];
      if (dur >= span) begin
        tally[ring_head[at]] += share(span, ring_cnt[at], dur);
        break;
      end
      span -= dur;
      tally[ring_head[at]] += TIME_W'(ring_cnt[at]);
      at = back;
    end
  endtask

  function automatic logic [HEAD_W-1:0] pick_winner(logic [TIME_W-1:0] tally[NHEAD+1]);
    logic [HEAD_W-1:0] best;
    logic [TIME_W-1:0] top;
    best = UNKNOWN;
    top = 0;
    for (int i = 0; i < NHEAD; i++)
      if (tally[i] > top) begin
        top = tally[i];
        best = HEAD_W'(i);
      end
    return best;
  endfunction

  task automatic vote_window(logic [TIME_W-1:0] fin, logic [TIME_W-1:0] span,
                             output logic [HEAD_W-1:0] best);
    logic [TIME_W-1:0] tally[NHEAD+1];
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] part_span;
    int unsigned e;
    int unsigned p;
    foreach (tally[i]) tally[i] = 0;
    if (fin >= ring_stamp[newest]) begin
      gap = fin - ring_stamp[newest];
      span = (gap > span) ? 0 : span - gap;
      if (span == 0) begin
        best = ring_head[newest];
        return;
      end
      tally_back(newest, span, tally);
      best = pick_winner(tally);
      return;
    end
    e = newest;
    p = prev_slot(e);
    while (p != newest && ring_stamp[p] > fin) begin
      e = p;
      p = prev_slot(e);
    end
    if (p == newest) begin
      best = ring_head[e];
      return;
    end
    part_span = fin - ring_stamp[p];
    if (part_span >= span) begin
      best = ring_head[e];
      return;
    end
    tally_back(p, span - part_span, tally);
    tally[ring_head[e]] += share(part_span, ring_cnt[e], ring_stamp[e] - ring_stamp[p]);
    best = pick_winner(tally);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [TIME_W-1:0] stamp;
    logic [HEAD_W-1:0] head;
    logic [HEAD_W-1:0] best;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring_head[i] = UNKNOWN;
        ring_stamp[i] = 0;
        ring_cnt[i] = 0;
      end
      newest = 0;
      answer_q.delete();
      fail_count = 0;
      pending_answers = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", out_tdata[3:0]));
        else begin
          best = answer_q.pop_front();
          if (out_tdata[3:0] !== best || out_tdata[7:4] !== 4'd0)
            report_mismatch($sformatf("best_heading %0d, expected %0d",
                                      out_tdata, best));
        end
      end
      if (in_tvalid && in_tready) begin
        stamp = in_tdata[31:0];
        if (in_tuser == FUNC_QUERY) begin
          vote_window(stamp, in_tdata[67:36], best);
          answer_q = {answer_q, best};
        end else begin
          head = in_tdata[35:32];
          if (head > UNKNOWN) head = UNKNOWN;
          if (ring_head[newest] == head) begin
            ring_stamp[newest] = stamp;
            if (ring_cnt[newest] != SAMPLES_MAX) ring_cnt[newest]++;
          end else begin
            newest = (newest + 1 == DEPTH) ? 0 : newest + 1;
            ring_head[newest] = head;
            ring_stamp[newest] = stamp;
            ring_cnt[newest] = 1;
          end
        end
      end
      pending_answers = answer_q.size();
    end
  end

endmodule

// File: tb/tb_direction_history_window_vote.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direction_history_window_vote
// drives direction samples and window queries into the vote block: directed
// corner cases, then runs of samples on a moving clock mixed with queries,
// with random gaps on both channels and a long receiver stall
// ----------------------------------------------------------------------------
module tb_direction_history_window_vote import dhwv_pkg::*;;

  localparam int WATCH_LIMIT = 20000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     pending_answers;
  int                     idle_cycles;
  logic                   hold_receiver;
  logic                   stim_done;
  logic [31:0]            now_ms;
  logic [3:0]             cur_head;

  direction_history_window_vote u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  dhwv_vote_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_answers(pending_answers)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // returns right after the accepting edge, in_tvalid still high
  task automatic send(logic func, logic [31:0] stamp, logic [3:0] head, logic [31:0] win);
    int unsigned g;
    g = stim_done ? 0 : gap_len();
    if ($urandom_range(0, 3) == 0) g = 0;
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'd0, win, head, stamp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic sample_at(logic [31:0] stamp, logic [3:0] head);
    send(FUNC_SAMPLE, stamp, head, $urandom);
  endtask

  task automatic query_at(logic [31:0] stamp, logic [31:0] win);
    send(FUNC_QUERY, stamp, 4'($urandom_range(0, 15)), win);
  endtask

  // receiver: random stalls, plus one long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_receiver) out_tready <= 1'b0;
      else out_tready <= ($urandom_range(0, 5) != 0);
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    hold_receiver = 1'b0;
    stim_done = 1'b0;
    idle_cycles = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty history, extremes, unknown and out-of-range headings
    query_at(32'd0, 32'd0);
    query_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sample_at(32'd100, 4'd0);
    sample_at(32'd100, 4'd0);
    sample_at(32'd150, 4'd11);
    sample_at(32'd160, 4'd15);
    sample_at(32'd170, 4'd12);
    sample_at(32'd200, 4'd5);
    sample_at(32'd200, 4'd3);
    sample_at(32'd260, 4'd5);
    query_at(32'd260, 32'd0);
    query_at(32'd500, 32'd100);
    query_at(32'd260, 32'd1000);
    query_at(32'd180, 32'd50);
    query_at(32'd155, 32'd3);
    query_at(32'd50, 32'd10);
    query_at(32'd230, 32'hFFFF_FFFF);
    sample_at(32'hFFFF_FFF0, 4'd7);
    sample_at(32'h0000_0010, 4'd2);
    query_at(32'h0000_0010, 32'd40);
    query_at(32'hFFFF_FFFF, 32'd1);

    // random part: a moving time base with runs of repeated headings
    now_ms = $urandom;
    cur_head = 4'($urandom_range(0, 12));
    n = 0;
    while (n < 1250) begin
      if (n == 400) begin
        // receiver holds off while queries keep coming
        fork
          begin
            hold_receiver = 1'b1;
            repeat (3000) @(posedge clk);
            hold_receiver = 1'b0;
          end
          begin
            for (int k = 0; k < 6; k++) begin
              query_at(now_ms, $urandom_range(0, 500));
              n++;
            end
            idle_input();
          end
        join
        // sender waits for every answer
        while (pending_answers != 0) @(negedge clk);
      end
      if ($urandom_range(0, 3) != 0) begin
        now_ms += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
        if ($urandom_range(0, 2) == 0) cur_head = 4'($urandom_range(0, 15));
        sample_at(now_ms, cur_head);
      end else begin
        case ($urandom_range(0, 4))
          0: query_at(now_ms + $urandom_range(0, 50), $urandom_range(0, 2000));
          1: query_at(now_ms - $urandom_range(0, 3000), $urandom_range(0, 800));
          2: query_at($urandom, $urandom);
          default: query_at(now_ms, $urandom_range(1, 300));
        endcase
      end
      n++;
    end

    stim_done = 1'b1;
    idle_input();
    while (pending_answers != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
